### rtl/core/tpef_pkg.sv
// ----------------------------------------------------------------------------
// tpef_pkg
// Shared widths, microcode encoding and helpers of the tared pressure filter.
// ----------------------------------------------------------------------------
package tpef_pkg;

    // converter resolution and derived widths
    localparam int ADC_BITS  = 12;
    localparam int RAW_W     = 16;                   // s_tdata width, raw field padded
    localparam int NCNT_W    = 7;                    // cal_samples / cal_seen
    localparam int ALPHA_W   = 17;
    localparam int GAIN_W    = 18;
    localparam int PERIOD_W  = 10;
    localparam int P_W       = 20;                   // pressure, signed Q12.8
    localparam int SUM_W     = ADC_BITS + 6;
    localparam int OFS_W     = ADC_BITS + 8;
    localparam int DVD_W     = SUM_W + 8;
    localparam int DIFF_W    = OFS_W + 1;
    localparam int MUL_A_W   = (DIFF_W > P_W + 1) ? DIFF_W : P_W + 1;
    localparam int MUL_B_W   = GAIN_W;
    localparam int MUL_W     = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W     = MUL_W + 2;
    localparam int FRAC_Q    = 16;
    localparam int CAL_MAX   = 64;
    localparam int ALPHA_ONE = 65536;
    localparam int P_MAX     = 2 ** (P_W - 1) - 1;
    localparam int OUT_W     = ((P_W + 7) / 8) * 8;

    // register map, byte address = 4 * index
    localparam int PADDR_W   = 4;
    localparam logic [1:0] REG_CAL_SAMPLES   = 2'd0;
    localparam logic [1:0] REG_ALPHA_Q16     = 2'd1;
    localparam logic [1:0] REG_GAIN_Q16      = 2'd2;
    localparam logic [1:0] REG_REPORT_PERIOD = 2'd3;

    localparam logic [NCNT_W-1:0]   RST_CAL_SAMPLES   = NCNT_W'(40);
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_Q16     = ALPHA_W'(9830);
    localparam logic [GAIN_W-1:0]   RST_GAIN_Q16      = GAIN_W'(19805);
    localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD = PERIOD_W'(300);

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CAL_ADD,
        OP_DIV_START,
        OP_SET_OFFSET,
        OP_MUL_PRESS,
        OP_ROUND_PRESS,
        OP_MUL_FILT,
        OP_ROUND_FILT,
        OP_SEED,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_VALID,
        C_CAL_DONE,
        C_CAL_MORE,
        C_DIV_BUSY,
        C_FIRST,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic cal_done;
        logic cal_more;
        logic div_busy;
        logic first;
        logic out_blocked;
    } dp_status_t;

    // program steps
    localparam step_t S_WAIT    = 4'd0;
    localparam step_t S_ROUTE   = 4'd1;
    localparam step_t S_CAL     = 4'd2;
    localparam step_t S_DIVGO   = 4'd3;
    localparam step_t S_DIVWAIT = 4'd4;
    localparam step_t S_OFFSET  = 4'd5;
    localparam step_t S_MULP    = 4'd6;
    localparam step_t S_PRESS   = 4'd7;
    localparam step_t S_MULF    = 4'd8;
    localparam step_t S_FILT    = 4'd9;
    localparam step_t S_SEED    = 4'd10;
    localparam step_t S_OUTWAIT = 4'd11;
    localparam step_t S_EMIT    = 4'd12;

    // control store: taken jump goes to target, otherwise next step
    function automatic ctrl_word_t ucode_rom(step_t pc);
        ctrl_word_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: S_WAIT};
        case (pc)
            S_WAIT:    w = '{op: OP_ACCEPT,      cond: C_NOT_VALID,   target: S_WAIT};
            S_ROUTE:   w = '{op: OP_NONE,        cond: C_CAL_DONE,    target: S_MULP};
            S_CAL:     w = '{op: OP_CAL_ADD,     cond: C_CAL_MORE,    target: S_WAIT};
            S_DIVGO:   w = '{op: OP_DIV_START,   cond: C_NEVER,       target: S_WAIT};
            S_DIVWAIT: w = '{op: OP_NONE,        cond: C_DIV_BUSY,    target: S_DIVWAIT};
            S_OFFSET:  w = '{op: OP_SET_OFFSET,  cond: C_ALWAYS,      target: S_WAIT};
            S_MULP:    w = '{op: OP_MUL_PRESS,   cond: C_NEVER,       target: S_WAIT};
            S_PRESS:   w = '{op: OP_ROUND_PRESS, cond: C_FIRST,       target: S_SEED};
            S_MULF:    w = '{op: OP_MUL_FILT,    cond: C_NEVER,       target: S_WAIT};
            S_FILT:    w = '{op: OP_ROUND_FILT,  cond: C_ALWAYS,      target: S_OUTWAIT};
            S_SEED:    w = '{op: OP_SEED,        cond: C_NEVER,       target: S_WAIT};
            S_OUTWAIT: w = '{op: OP_NONE,        cond: C_OUT_BLOCKED, target: S_OUTWAIT};
            S_EMIT:    w = '{op: OP_EMIT,        cond: C_ALWAYS,      target: S_WAIT};
            default:   w = '{op: OP_NONE,        cond: C_ALWAYS,      target: S_WAIT};
        endcase
        return w;
    endfunction

    // divide by 2^16 rounding half up, then clamp to the pressure range
    function automatic logic signed [P_W-1:0] round_sat(logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(P_MAX);
        lo = -hi - ACC_W'(1);
        s  = (x + ACC_W'(2 ** (FRAC_Q - 1))) >>> FRAC_Q;
        if (s > hi) begin
            return P_W'(hi);
        end else if (s < lo) begin
            return P_W'(lo);
        end
        return s[P_W-1:0];
    endfunction

endpackage

### rtl/core/tpef_div.sv
// ----------------------------------------------------------------------------
// tpef_div
// Restoring divider for the tare offset, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpef_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tpef_pkg::DVD_W-1:0]   dividend,
    input  logic [tpef_pkg::NCNT_W-1:0]  divisor,
    output logic                         busy,
    output logic [tpef_pkg::DVD_W-1:0]   quotient
);
    import tpef_pkg::*;

    localparam int REM_W = NCNT_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [NCNT_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign trial = {rem_reg[REM_W-2:0], work_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial - {1'b0, dsr_reg} : trial;
            work_next = {work_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

### rtl/core/tpef_seq.sv
// ----------------------------------------------------------------------------
// tpef_seq
// Step counter and control store; branches on datapath status flags.
// ----------------------------------------------------------------------------
module tpef_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  tpef_pkg::dp_status_t  status,
    output tpef_pkg::ctrl_word_t  ctrl
);
    import tpef_pkg::*;

    step_t      pc_reg, pc_next;
    ctrl_word_t word;
    logic       taken;

    assign word = ucode_rom(pc_reg);

    always_comb begin
        unique case (word.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NOT_VALID:   taken = !in_valid;
            C_CAL_DONE:    taken = status.cal_done;
            C_CAL_MORE:    taken = status.cal_more;
            C_DIV_BUSY:    taken = status.div_busy;
            C_FIRST:       taken = status.first;
            C_OUT_BLOCKED: taken = status.out_blocked;
            default:       taken = 1'b1;
        endcase
        pc_next = taken ? word.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

### rtl/core/tpef_datapath.sv
// ----------------------------------------------------------------------------
// tpef_datapath
// Calibration sums, shared multiplier, rounding, filter state and output word.
// ----------------------------------------------------------------------------
module tpef_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tpef_pkg::ctrl_word_t           ctrl,
    output tpef_pkg::dp_status_t           status,
    input  logic                           in_valid,
    input  logic [tpef_pkg::ADC_BITS-1:0]  raw_in,
    input  logic [tpef_pkg::NCNT_W-1:0]    cal_samples,
    input  logic [tpef_pkg::ALPHA_W-1:0]   alpha_q16,
    input  logic [tpef_pkg::GAIN_W-1:0]    gain_q16,
    input  logic [tpef_pkg::PERIOD_W-1:0]  report_period,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [tpef_pkg::P_W-1:0] out_pressure,
    output logic                           out_due
);
    import tpef_pkg::*;

    logic [ADC_BITS-1:0]       raw_reg;
    logic [NCNT_W-1:0]         cal_seen_reg;
    logic [SUM_W-1:0]          cal_sum_reg;
    logic [OFS_W-1:0]          zero_offset_reg;
    logic signed [P_W-1:0]     filter_reg;
    logic signed [P_W-1:0]     press_reg;
    logic                      first_reg;
    logic [PERIOD_W-1:0]       period_count_reg;
    logic signed [MUL_W-1:0]   prod_reg;
    logic                      out_valid_reg;
    logic signed [P_W-1:0]     out_pressure_reg;
    logic                      out_due_reg;

    logic [NCNT_W-1:0]         n_eff;
    logic [ALPHA_W-1:0]        alpha_eff;
    logic [NCNT_W:0]           seen_inc;
    logic                      div_busy;
    logic [DVD_W-1:0]          quotient;
    logic [DVD_W-1:0]          dividend;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [P_W:0]       pf_diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [ACC_W-1:0]   filt_acc;
    logic [PERIOD_W:0]         period_inc;
    logic                      due;

    // clamped register views
    always_comb begin
        if (cal_samples == '0) begin
            n_eff = NCNT_W'(1);
        end else if (cal_samples > NCNT_W'(CAL_MAX)) begin
            n_eff = NCNT_W'(CAL_MAX);
        end else begin
            n_eff = cal_samples;
        end
        if (alpha_q16 == '0) begin
            alpha_eff = ALPHA_W'(1);
        end else if (alpha_q16 > ALPHA_W'(ALPHA_ONE)) begin
            alpha_eff = ALPHA_W'(ALPHA_ONE);
        end else begin
            alpha_eff = alpha_q16;
        end
    end

    assign seen_inc = {1'b0, cal_seen_reg} + (NCNT_W + 1)'(1);

    assign status.cal_done    = !(cal_seen_reg < n_eff);
    assign status.cal_more    = seen_inc < {1'b0, n_eff};
    assign status.div_busy    = div_busy;
    assign status.first       = first_reg;
    assign status.out_blocked = out_valid_reg && !out_ready;

    // rounded mean in Q.8 counts
    assign dividend = {cal_sum_reg, 8'b0} + DVD_W'(n_eff >> 1);

    tpef_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.op == OP_DIV_START),
        .dividend (dividend),
        .divisor  (n_eff),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // single shared multiplier: tare difference * gain, or (p - f) * alpha
    assign diff    = $signed({1'b0, zero_offset_reg}) - $signed({1'b0, raw_reg, 8'b0});
    assign pf_diff = (P_W + 1)'(press_reg) - (P_W + 1)'(filter_reg);

    always_comb begin
        if (ctrl.op == OP_MUL_FILT) begin
            mul_a = MUL_A_W'(pf_diff);
            mul_b = MUL_B_W'(alpha_eff);
        end else begin
            mul_a = MUL_A_W'(diff);
            mul_b = gain_q16;
        end
    end

    // f + alpha*(p - f) in Q16, same as alpha*p + (1 - alpha)*f
    assign filt_acc = (ACC_W'(filter_reg) <<< FRAC_Q) + ACC_W'(prod_reg);

    assign period_inc = {1'b0, period_count_reg} + (PERIOD_W + 1)'(1);
    assign due        = period_inc >= {1'b0, report_period};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_seen_reg     <= '0;
            cal_sum_reg      <= '0;
            zero_offset_reg  <= '0;
            filter_reg       <= '0;
            first_reg        <= 1'b1;
            period_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_CAL_ADD: begin
                    cal_sum_reg <= cal_sum_reg + SUM_W'(raw_reg);
                    // a finished calibration parks the count at CAL_MAX, which any setting reads as done
                    cal_seen_reg <= status.cal_more ? seen_inc[NCNT_W-1:0]
                                                    : NCNT_W'(CAL_MAX);
                end
                OP_SET_OFFSET: zero_offset_reg <= quotient[OFS_W-1:0];
                OP_ROUND_FILT: filter_reg <= round_sat(filt_acc);
                OP_SEED: begin
                    filter_reg <= press_reg;
                    first_reg  <= 1'b0;
                end
                OP_EMIT: begin
                    out_valid_reg    <= 1'b1;
                    period_count_reg <= due ? '0 : period_inc[PERIOD_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_ACCEPT && in_valid) begin
            raw_reg <= raw_in;
        end
        if (ctrl.op == OP_MUL_PRESS || ctrl.op == OP_MUL_FILT) begin
            prod_reg <= mul_a * $signed({1'b0, mul_b});
        end
        if (ctrl.op == OP_ROUND_PRESS) begin
            press_reg <= round_sat(ACC_W'(prod_reg));
        end
        if (ctrl.op == OP_EMIT) begin
            out_pressure_reg <= filter_reg;
            out_due_reg      <= due;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pressure = out_pressure_reg;
    assign out_due      = out_due_reg;

endmodule

### rtl/core/tared_pressure_ema_filter.sv
// ----------------------------------------------------------------------------
// tared_pressure_ema_filter
// Tared pressure conversion with exponential moving average, APB registers.
// ----------------------------------------------------------------------------
// One sample is handled at a time by a microcoded sequencer over a datapath
// with a single shared multiplier. A calibration sample gives no word; the
// last one also runs the offset divider, one quotient bit per cycle. After
// calibration a sample is multiplied and rounded to a pressure, then the
// filter is multiplied and rounded (the first sample seeds it instead)
// before the result word is emitted; the next sample is taken while the
// result still waits in the output register, and only a second result
// waiting on a stalled m_tready holds the program.
module tared_pressure_ema_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // raw_sample [11:0], zero [15:12]
    input  logic [tpef_pkg::RAW_W-1:0]    s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // filtered_pressure [19:0], zero [23:20]
    output logic [tpef_pkg::OUT_W-1:0]    m_tdata,
    // report_due [0]
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpef_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tpef_pkg::*;

    logic [NCNT_W-1:0]     cal_samples_reg;
    logic [ALPHA_W-1:0]    alpha_q16_reg;
    logic [GAIN_W-1:0]     gain_q16_reg;
    logic [PERIOD_W-1:0]   report_period_reg;
    logic                  wr_en;
    logic [1:0]            reg_idx;
    ctrl_word_t            ctrl;
    dp_status_t            status;
    logic signed [P_W-1:0] pressure;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg   <= RST_CAL_SAMPLES;
            alpha_q16_reg     <= RST_ALPHA_Q16;
            gain_q16_reg      <= RST_GAIN_Q16;
            report_period_reg <= RST_REPORT_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CAL_SAMPLES:   cal_samples_reg   <= pwdata[NCNT_W-1:0];
                REG_ALPHA_Q16:     alpha_q16_reg     <= pwdata[ALPHA_W-1:0];
                REG_GAIN_Q16:      gain_q16_reg      <= pwdata[GAIN_W-1:0];
                REG_REPORT_PERIOD: report_period_reg <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CAL_SAMPLES:   prdata = 32'(cal_samples_reg);
            REG_ALPHA_Q16:     prdata = 32'(alpha_q16_reg);
            REG_GAIN_Q16:      prdata = 32'(gain_q16_reg);
            REG_REPORT_PERIOD: prdata = 32'(report_period_reg);
            default:           prdata = '0;
        endcase
    end

    tpef_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl)
    );

    tpef_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .status        (status),
        .in_valid      (s_tvalid),
        .raw_in        (s_tdata[ADC_BITS-1:0]),
        .cal_samples   (cal_samples_reg),
        .alpha_q16     (alpha_q16_reg),
        .gain_q16      (gain_q16_reg),
        .report_period (report_period_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_pressure  (pressure),
        .out_due       (m_tuser)
    );

    assign s_tready = ctrl.op == OP_ACCEPT;
    assign m_tdata  = {{(OUT_W - P_W){1'b0}}, pressure};

endmodule

### verif/tb_tared_pressure_ema_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tared_pressure_ema_filter
// Stream-level check of the tared pressure filter: start-up calibration,
// pressure conversion with saturation, the moving average and the report
// flag. Registers are set over APB between phases. Each accepted sample is
// run through an in-bench model and every output word is compared in order.
// Both stream sides idle at random, apart from one back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_tared_pressure_ema_filter;
    import tpef_pkg::*;

    typedef struct packed {
        logic signed [P_W-1:0] pressure;
        logic                  report;
    } reading_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [RAW_W-1:0]     s_tdata  = '0;   // raw_sample [11:0], zero [15:12]
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;         // filtered_pressure [19:0], zero [23:20]
    logic                 m_tuser;         // report_due [0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // register copies
    logic [NCNT_W-1:0]    cal_cfg    = RST_CAL_SAMPLES;
    logic [ALPHA_W-1:0]   alpha_cfg  = RST_ALPHA_Q16;
    logic [GAIN_W-1:0]    gain_cfg   = RST_GAIN_Q16;
    logic [PERIOD_W-1:0]  period_cfg = RST_REPORT_PERIOD;

    // filter state
    longint cal_seen      = 0;
    longint cal_sum       = 0;
    longint zero_ofs      = 0;
    longint filt          = 0;
    bit     seed_next     = 1'b1;
    longint since_report  = 0;

    reading_t pending_readings[$];
    int       mismatches = 0;
    bit       gaps_on    = 1'b1;

    tared_pressure_ema_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_tared_pressure_ema_filter: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 33);
    end

    // divide by 2^16, half rounds up
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp_p20(input longint v);
        if (v > 524287) begin
            return 524287;
        end
        if (v < -524288) begin
            return -524288;
        end
        return v;
    endfunction

    // calibrate on, or tare, convert and filter, one sample; queue any word it produces
    function automatic void advance_filter(input logic [ADC_BITS-1:0] raw);
        longint   n;
        longint   r;
        longint   g;
        longint   a;
        longint   p;
        reading_t w;
        n = cal_cfg;
        if (n == 0) n = 1;
        if (n > CAL_MAX) n = CAL_MAX;
        r = raw;
        if (cal_seen < n) begin
            cal_sum  += r;
            cal_seen += 1;
            if (cal_seen >= n) begin
                zero_ofs = (cal_sum * 256 + n / 2) / n;
                cal_seen = CAL_MAX;
            end
            return;
        end
        g = gain_cfg;
        p = clamp_p20(round_q16((zero_ofs - r * 256) * g));
        if (seed_next) begin
            filt      = p;
            seed_next = 1'b0;
        end else begin
            a = alpha_cfg;
            if (a == 0) a = 1;
            if (a > ALPHA_ONE) a = ALPHA_ONE;
            filt = clamp_p20(round_q16(a * p + (ALPHA_ONE - a) * filt));
        end
        w.pressure   = filt[P_W-1:0];
        w.report     = 1'b0;
        since_report += 1;
        if (since_report >= longint'(period_cfg)) begin
            w.report     = 1'b1;
            since_report = 0;
        end
        pending_readings.push_back(w);
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: word with nothing pending, pressure %0d report %0b",
                         $time, $signed(m_tdata[P_W-1:0]), m_tuser);
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[P_W-1:0] !== want.pressure) begin
                    mismatches++;
                    $display("%0t: pressure expected %0d, got %0d",
                             $time, want.pressure, $signed(m_tdata[P_W-1:0]));
                end
                if (m_tuser !== want.report) begin
                    mismatches++;
                    $display("%0t: report flag expected %0b, got %0b",
                             $time, want.report, m_tuser);
                end
            end
        end
    end

    task automatic send_raw(input logic [ADC_BITS-1:0] raw);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 33) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= RAW_W'(raw);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_filter(raw);
    endtask

    // drain all words, then leave room for a divide still running
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_SAMPLES:   cal_cfg    = value[NCNT_W-1:0];
            REG_ALPHA_Q16:     alpha_cfg  = value[ALPHA_W-1:0];
            REG_GAIN_Q16:      gain_cfg   = value[GAIN_W-1:0];
            REG_REPORT_PERIOD: period_cfg = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    // mix of full-range readings, readings near the tare point and rails
    function automatic logic [ADC_BITS-1:0] pick_raw();
        int c;
        case ($urandom_range(0, 3))
            0: begin
                c = int'(zero_ofs >>> 8) + int'($urandom_range(0, 64)) - 32;
                if (c < 0) c = 0;
                if (c > 4095) c = 4095;
                return ADC_BITS'(c);
            end
            1: return $urandom_range(0, 1) ? ADC_BITS'(4095) : ADC_BITS'(0);
            default: return ADC_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_calibration();
        program_reg(REG_CAL_SAMPLES, 32'd0);
        program_reg(REG_CAL_SAMPLES, 32'd127);
        send_raw(12'd4095);
        send_raw(12'd0);
        send_raw(12'd4095);
        send_raw(12'd0);
        send_raw(12'd4095);
        // count lowered part way through, still above samples taken
        program_reg(REG_CAL_SAMPLES, 32'd9);
        send_raw(12'd0);
        send_raw(12'd4095);
        send_raw(ADC_BITS'($urandom_range(0, 4095)));
        send_raw(ADC_BITS'($urandom_range(0, 4095)));
        // no effect once the offset is set
        program_reg(REG_CAL_SAMPLES, 32'd0);
    endtask

    task automatic test_pressure_extremes();
        send_raw(12'd0);                        // seeds the average
        send_raw(12'd4095);
        send_raw(ADC_BITS'(zero_ofs >>> 8));
        send_raw(12'd1);
        send_raw(12'd4094);
        program_reg(REG_GAIN_Q16, 32'hFFFF_FFFF);
        send_raw(12'd0);
        send_raw(12'd4095);
        program_reg(REG_GAIN_Q16, 32'd0);
        program_reg(REG_REPORT_PERIOD, 32'd0);
        send_raw(12'd2);
        program_reg(REG_GAIN_Q16, 32'd19805);
        program_reg(REG_ALPHA_Q16, 32'd0);
        send_raw(12'd0);
        send_raw(12'd4095);
        program_reg(REG_ALPHA_Q16, 32'h1FFFF);
        send_raw(12'd4095);
        send_raw(12'd0);
    endtask

    task automatic test_report_period();
        program_reg(REG_ALPHA_Q16, 32'd9830);
        program_reg(REG_REPORT_PERIOD, 32'd1023);
        repeat (30) send_raw(pick_raw());
        // shortened below the running count
        program_reg(REG_REPORT_PERIOD, 32'd7);
        repeat (40) send_raw(pick_raw());
        program_reg(REG_REPORT_PERIOD, 32'd1);
        repeat (10) send_raw(pick_raw());
    endtask

    task automatic test_random_settings();
        repeat (6) begin
            case ($urandom_range(0, 4))
                0: program_reg(REG_ALPHA_Q16, 32'd0);
                1: program_reg(REG_ALPHA_Q16, 32'd1);
                2: program_reg(REG_ALPHA_Q16, 32'd65536);
                3: program_reg(REG_ALPHA_Q16, 32'h1FFFF);
                default: program_reg(REG_ALPHA_Q16, $urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: program_reg(REG_GAIN_Q16, 32'd0);
                1: program_reg(REG_GAIN_Q16, 32'd262143);
                2: program_reg(REG_GAIN_Q16, $urandom_range(0, 262143));
                default: program_reg(REG_GAIN_Q16, $urandom_range(8000, 40000));
            endcase
            case ($urandom_range(0, 3))
                0: program_reg(REG_REPORT_PERIOD, 32'd0);
                1: program_reg(REG_REPORT_PERIOD, 32'd1023);
                2: program_reg(REG_REPORT_PERIOD, $urandom_range(1, 1023));
                default: program_reg(REG_REPORT_PERIOD, $urandom_range(1, 12));
            endcase
            program_reg(REG_CAL_SAMPLES, $urandom_range(0, 127));
            repeat (100) send_raw(pick_raw());
        end
    endtask

    task automatic test_back_to_back();
        program_reg(REG_ALPHA_Q16, $urandom_range(1, 65536));
        program_reg(REG_GAIN_Q16, $urandom_range(0, 262143));
        program_reg(REG_REPORT_PERIOD, $urandom_range(1, 15));
        gaps_on = 1'b0;
        repeat (150) send_raw(pick_raw());
        settle();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_calibration();
        test_pressure_extremes();
        test_report_period();
        test_random_settings();
        test_back_to_back();
        settle();
        if (mismatches == 0) begin
            $display("tb_tared_pressure_ema_filter: done, clean");
        end else begin
            $display("tb_tared_pressure_ema_filter: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/tpef_pkg.sv
rtl/core/tpef_div.sv
rtl/core/tpef_seq.sv
rtl/core/tpef_datapath.sv
rtl/core/tared_pressure_ema_filter.sv
verif/tb_tared_pressure_ema_filter.sv
